// File: rtl/ilp_pkg.sv
// Shared character codes and types for the integer literal parser.
`default_nettype none

package ilp_pkg;

	// Width of the value field on the result channel.
	localparam int RESULT_BITS = 32;

	// ASCII codes that the parser recognizes.
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_B = 8'h42;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Status that travels from the parse stage to the result register.
	typedef struct packed {
		logic valid;
		logic negative;
		logic error;
	} parse_res_t;

endpackage

`default_nettype wire

// File: rtl/ilp_parse.sv
// Parse state machine with the per-character accumulate step.
`default_nettype none

module ilp_parse
	import ilp_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            char_code,
	input  wire logic                  last_char,
	output logic      [VALUE_BITS-1:0] acc_next,
	output parse_res_t                 res
);

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_PREFIX = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_ERROR  = 2'd3;

	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_HEX = 2'd1;
	localparam logic [1:0] RX_BIN = 2'd2;

	logic [1:0]            phase_q;
	logic                  negative_q;
	logic [1:0]            radix_q;
	logic [VALUE_BITS-1:0] acc_q;

	logic [1:0]            phase_next;
	logic                  negative_next;
	logic [1:0]            radix_next;
	logic [7:0]            ch;
	logic [5:0]            digit;
	logic                  is_digit_char;
	logic [5:0]            radix_val;
	logic [VALUE_BITS-1:0] acc_scaled;

	// Fold lower case letters to upper case.
	always_comb begin
		if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
			ch = char_code - CASE_OFFSET;
		end else begin
			ch = char_code;
		end
	end

	// Digit value of the folded character, for radices up to 36.
	always_comb begin
		digit = '0;
		is_digit_char = 1'b0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			digit = 6'(ch - CH_ZERO);
			is_digit_char = 1'b1;
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			digit = 6'(ch - CH_UPPER_A) + 6'd10;
			is_digit_char = 1'b1;
		end
	end

	// Radix value and the shifted accumulator; the unused code reads as decimal.
	always_comb begin
		case (radix_q)
			RX_HEX: begin
				radix_val = 6'd16;
				acc_scaled = acc_q << 4;
			end
			RX_BIN: begin
				radix_val = 6'd2;
				acc_scaled = acc_q << 1;
			end
			default: begin
				radix_val = 6'd10;
				acc_scaled = (acc_q << 3) + (acc_q << 1);
			end
		endcase
	end

	// Next state for the current character.
	always_comb begin
		phase_next = phase_q;
		negative_next = negative_q;
		radix_next = radix_q;
		acc_next = acc_q;
		unique case (phase_q)
			PH_START: begin
				if (ch == CH_MINUS) begin
					negative_next = 1'b1;
					radix_next = RX_DEC;
					phase_next = PH_DIGITS;
				end else if (ch == CH_PLUS) begin
					negative_next = 1'b0;
					radix_next = RX_DEC;
					phase_next = PH_DIGITS;
				end else if (ch == CH_ZERO) begin
					phase_next = PH_PREFIX;
				end else if (ch >= CH_ONE && ch <= CH_NINE) begin
					negative_next = 1'b0;
					radix_next = RX_DEC;
					phase_next = PH_DIGITS;
					acc_next = VALUE_BITS'(digit);
				end else begin
					phase_next = PH_ERROR;
				end
			end
			PH_PREFIX: begin
				if (ch == CH_UPPER_X) begin
					radix_next = RX_HEX;
					phase_next = PH_DIGITS;
				end else if (ch == CH_UPPER_B) begin
					radix_next = RX_BIN;
					phase_next = PH_DIGITS;
				end else begin
					phase_next = PH_ERROR;
				end
			end
			PH_DIGITS: begin
				if (is_digit_char && digit < radix_val) begin
					acc_next = acc_scaled + VALUE_BITS'(digit);
				end else begin
					phase_next = PH_ERROR;
				end
			end
			PH_ERROR: begin
				phase_next = PH_ERROR;
			end
			default: begin
				phase_next = PH_ERROR;
			end
		endcase
	end

	// Status for the result register; only meaningful with res.valid.
	assign res.valid = step && last_char;
	assign res.negative = negative_next;
	assign res.error = (phase_next == PH_ERROR);

	// State registers; the end of a literal returns to the start state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			negative_q <= 1'b0;
			radix_q <= RX_DEC;
			acc_q <= '0;
		end else if (step) begin
			if (last_char) begin
				phase_q <= PH_START;
				negative_q <= 1'b0;
				radix_q <= RX_DEC;
				acc_q <= '0;
			end else begin
				phase_q <= phase_next;
				negative_q <= negative_next;
				radix_q <= radix_next;
				acc_q <= acc_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/ilp_result.sv
// Sign handling, width fitting and the output register of the parser.
`default_nettype none

module ilp_result
	import ilp_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic      [VALUE_BITS-1:0]   acc,
	input  wire parse_res_t                   res,
	input  wire logic                         result_stall,
	output logic                              result_valid,
	output logic signed    [RESULT_BITS-1:0]  value,
	output logic                              invalid
);

	logic [VALUE_BITS-1:0]  signed_acc;
	logic [RESULT_BITS-1:0] fitted;
	logic                   valid_q;
	logic [RESULT_BITS-1:0] value_q;
	logic                   invalid_q;

	// Apply the sign modulo the accumulator width.
	assign signed_acc = res.negative ? (~acc + VALUE_BITS'(1)) : acc;

	// Sign-extend or cut the value to the result width.
	generate
		if (VALUE_BITS >= RESULT_BITS) begin : g_cut
			assign fitted = signed_acc[RESULT_BITS-1:0];
		end else begin : g_ext
			assign fitted = {{(RESULT_BITS-VALUE_BITS){signed_acc[VALUE_BITS-1]}}, signed_acc};
		end
	endgenerate

	// Output register; a new result loads only when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			value_q <= fitted;
			invalid_q <= res.error;
		end
	end

	assign result_valid = valid_q;
	assign value = signed'(value_q);
	assign invalid = invalid_q;

endmodule

`default_nettype wire

// File: rtl/integer_literal_parser.sv
// Top level of the integer literal parser.
`default_nettype none

// Parses one integer literal per run of characters: an optional sign and
// decimal digits, a 0x or 0b prefix with hex or binary digits, or a plain
// decimal number. Letters may be in either case. One character is taken per
// cycle with no gaps between literals unless char_stall holds the input; the
// single accumulate stage (a shift and add on the VALUE_BITS wide
// accumulator) sets that rate. A last character is registered at the input
// and its result at the output; a waiting result stalls the input only at
// the next literal's last character. The value wraps modulo 2^VALUE_BITS, is
// negated for a minus sign and is then sign-extended or cut to 32 bits.
module integer_literal_parser
	import ilp_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      char_valid,
	output logic                           char_stall,
	input  wire logic [7:0]                char_code,
	input  wire logic                      last_char,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output logic signed [RESULT_BITS-1:0]  value,
	output logic                           invalid
);

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;
	logic                  advance;
	logic                  step;
	logic [VALUE_BITS-1:0] acc_next;
	parse_res_t            res;

	// The parse stage holds only when it would emit a result into a full slot.
	assign advance = !(last_s1 && result_valid && result_stall);
	assign step = valid_s1 && advance;
	assign char_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	ilp_parse #(
		.VALUE_BITS(VALUE_BITS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.char_code(char_s1),
		.last_char(last_s1),
		.acc_next(acc_next),
		.res(res)
	);

	ilp_result #(
		.VALUE_BITS(VALUE_BITS)
	) u_result (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc_next),
		.res(res),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.value(value),
		.invalid(invalid)
	);

endmodule

`default_nettype wire

// File: rtl/ilp_checker.sv
// Port-level assertions for the integer literal parser and their binding.
`default_nettype none

module ilp_port_checker
	import ilp_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     char_valid,
	input wire logic                     char_stall,
	input wire logic                     last_char,
	input wire logic                     result_valid,
	input wire logic                     result_stall,
	input wire logic [RESULT_BITS-1:0]   value,
	input wire logic                     invalid
);

	// No result is shown while reset is held.
	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result shown during reset");

	// A stalled result keeps its value and flag.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(value) && $stable(invalid))
		else $error("stalled result changed");

	// Characters are held back only by a full, stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> result_valid && result_stall)
		else $error("input stalled without a blocked result");

	// A transferred last character yields a result unless a stalled result blocks the parse stage.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && last_char) ##1 !(result_valid && result_stall)
		|=> result_valid)
		else $error("missing result after last character");

endmodule

bind integer_literal_parser ilp_port_checker u_ilp_port_checker (.*);

`default_nettype wire
